[rtl/fir_pkg.sv]
// Shared types and widths for the FIR filter.
package fir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int INDEX_W  = 5;
    localparam int TAPCNT_W = 6;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int FRAC_W   = 16;

    localparam logic OP_SAMPLE     = 1'b0;
    localparam logic OP_COEF_WRITE = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic shift;   // take the left neighbor's sample, cell 0 takes the new one
        logic rotate;  // take sample and coefficient from the right neighbor
    } cell_ctrl_t;

endpackage

[rtl/fir_cell.sv]
// One tap cell: a delay-line sample and its coefficient.
module fir_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fir_pkg::cell_ctrl_t          ctrl,
    input  logic signed [15:0]           shift_in,
    input  logic signed [15:0]           rot_dly_in,
    input  logic signed [23:0]           rot_coef_in,
    input  logic                         coef_we,
    input  logic signed [23:0]           coef_wdata,
    output logic signed [15:0]           dly,
    output logic signed [23:0]           coef
);
    import fir_pkg::*;

    logic signed [SAMPLE_W-1:0] dly_reg;
    logic signed [COEF_W-1:0]   coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                dly_reg <= shift_in;
            end
            else if (ctrl.rotate)
            begin
                dly_reg <= rot_dly_in;
            end

            if (coef_we)
            begin
                coef_reg <= coef_wdata;
            end
            else if (ctrl.rotate)
            begin
                coef_reg <= rot_coef_in;
            end
        end
    end

    assign dly  = dly_reg;
    assign coef = coef_reg;

endmodule

[rtl/fir_mac.sv]
// Shared multiply-accumulate with truncate-toward-zero and saturation of the sum.
module fir_mac #(
    parameter int MAX_TAPS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         prod_en,
    input  logic signed [23:0]           coef,
    input  logic signed [15:0]           dly,
    output logic signed [15:0]           result,
    output logic                         sat
);
    import fir_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int Q_W   = ACC_W - FRAC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [Q_W-1:0]    q;
    logic                     over_hi;
    logic                     over_lo;

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= prod_en;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * dly;
    end

    // Bias negative sums so the arithmetic shift rounds toward zero.
    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
    assign q       = acc_adj[ACC_W-1:FRAC_W];
    assign over_hi = q > Q_W'(SAMPLE_MAX);
    assign over_lo = q < Q_W'(SAMPLE_MIN);

    always_comb
    begin
        if (over_hi)
        begin
            result = SAMPLE_MAX;
        end
        else if (over_lo)
        begin
            result = SAMPLE_MIN;
        end
        else
        begin
            result = q[SAMPLE_W-1:0];
        end
    end

    assign sat = over_hi | over_lo;

endmodule

[rtl/fir_filter.sv]
// Top level: chain of tap cells rotating past one shared multiply-accumulate.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | operation, sample_in, coef_index, coef_value
//  out      | out_valid / out_stall  | sample_out, saturated
//  cfg      | cfg_write              | cfg_data (tap count)
//
// A coefficient write or a warm-up sample does not stall the input.
// A sample that yields a result holds in_stall while the cell chain makes one full
// rotation through the MAC, then passes through the drain and finish states.
// The finish state waits while an earlier result is still stalled in the output register.
// Reset clears the delay line, coefficients, fill count and sets tap count to 1.
module fir_filter #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fir_pkg::TAPCNT_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [fir_pkg::INDEX_W-1:0]           coef_index,
    input  logic signed [fir_pkg::COEF_W-1:0]     coef_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fir_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                  saturated
);
    import fir_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS);
    localparam int N_W   = $clog2(MAX_TAPS + 1);
    localparam int TC_W  = (N_W > TAPCNT_W) ? N_W : TAPCNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                     state_reg;
    logic [TAPCNT_W-1:0]        tap_count_reg;
    logic [N_W-1:0]             fill_reg;
    logic [N_W-1:0]             fill_next;
    logic [N_W-1:0]             taps_reg;
    logic [N_W-1:0]             taps_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       saturated_reg;

    logic                       accept;
    logic                       take_sample;
    logic [TC_W-1:0]            tc_ext;
    cell_ctrl_t                 ctrl;

    logic signed [SAMPLE_W-1:0] dly   [MAX_TAPS];
    logic signed [COEF_W-1:0]   coefs [MAX_TAPS];

    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       mac_sat;

    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && (operation == OP_SAMPLE);
    assign in_stall    = (state_reg != S_IDLE);

    assign ctrl.shift  = take_sample;
    assign ctrl.rotate = (state_reg == S_ROT);

    // Effective tap count: zero means one, anything past the chain length is clamped.
    assign tc_ext = TC_W'(tap_count_reg);
    always_comb
    begin
        if (tc_ext == '0)
        begin
            taps_next = N_W'(1);
        end
        else if (tc_ext > TC_W'(MAX_TAPS))
        begin
            taps_next = N_W'(MAX_TAPS);
        end
        else
        begin
            taps_next = tc_ext[N_W-1:0];
        end
    end

    assign fill_next = (fill_reg < N_W'(MAX_TAPS)) ? fill_reg + N_W'(1) : fill_reg;

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        fir_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .shift_in    ((i == 0) ? sample_in : dly[(i + MAX_TAPS - 1) % MAX_TAPS]),
            .rot_dly_in  (dly[(i + 1) % MAX_TAPS]),
            .rot_coef_in (coefs[(i + 1) % MAX_TAPS]),
            .coef_we     (accept && (operation == OP_COEF_WRITE) && (32'(coef_index) == i)),
            .coef_wdata  (coef_value),
            .dly         (dly[i]),
            .coef        (coefs[i])
        );
    end

    // After cnt rotations cell 0 holds tap cnt.
    fir_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (state_reg == S_IDLE),
        .prod_en ((state_reg == S_ROT) && (N_W'(cnt_reg) < taps_reg)),
        .coef    (coefs[0]),
        .dly     (dly[0]),
        .result  (mac_result),
        .sat     (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tap_count_reg  <= TAPCNT_W'(1);
            fill_reg       <= '0;
            taps_reg       <= N_W'(1);
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                tap_count_reg <= cfg_data;
            end

            // Load a finished result, or drop one the receiver has taken.
            if ((state_reg == S_FIN) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (take_sample)
                    begin
                        fill_reg <= fill_next;
                        taps_reg <= taps_next;
                        if (fill_next >= taps_next)
                        begin
                            state_reg <= S_ROT;
                        end
                    end
                end
                S_ROT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MAX_TAPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        sample_out_reg <= mac_result;
                        saturated_reg  <= mac_sat;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule

[rtl/fir_checker.sv]
// Port-level checks on the FIR filter, bound to the top level.
module fir_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               operation,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample_out,
    input logic               saturated
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
        else $error("result changed while stalled");

    // A coefficient write never makes the block busy.
    a_coef_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation |=> !in_stall)
        else $error("coefficient write stalled the input");

    // The flag only comes with a clamped value.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> sample_out == 16'sh7fff || sample_out == 16'sh8000)
        else $error("saturated result not at a rail");

    // A new result only appears at the end of a busy period.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without computation");

endmodule

bind fir_filter fir_checker u_fir_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for fir_filter: a directed table, then random phases checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int MAX_TAPS      = 32;
    localparam int SETTLE_CYCLES = MAX_TAPS + 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 108;
    localparam int NUM_DIRECTED  = 25;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0]         idx;
        logic signed [COEF_W-1:0]   coef;
    } fir_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       sat;
    } fir_out_t;

    typedef enum logic {ROW_ITEM, ROW_TAPS} row_kind_t;
    typedef enum logic {CHK_MODEL, CHK_FIXED} row_check_t;

    typedef struct packed {
        row_kind_t           kind;
        fir_item_t           item;
        logic [TAPCNT_W-1:0] taps;
        row_check_t          chk;
        fir_out_t            fixed;
    } step_t;

    localparam fir_item_t NO_ITEM = '0;
    localparam fir_out_t  NO_OUT  = '0;

    localparam logic [TAPCNT_W-1:0] PHASE_TAPS [NUM_PHASES] =
        '{6'd32, 6'd63, 6'd1, 6'd33, 6'd5, 6'd17};

    // Tap count is 1 after reset, so the first samples already produce output.
    step_t directed_steps [NUM_DIRECTED] = '{
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh0000, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh0000, 1'b0}},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh7fff, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh0000, 1'b0}},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd0, 24'sh010000}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh8000, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh8000, 1'b0}},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd0, 24'sh7fffff}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh7fff, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh7fff, 1'b1}},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh8000, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh8000, 1'b1}},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd0, 24'sh800000}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh8000, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh7fff, 1'b1}},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh0001, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'shff80, 1'b0}},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd0, 24'shffffff}, 6'd0, CHK_MODEL, NO_OUT},
        // -1/65536 times 1 truncates toward zero, not down to -1
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh0001, 5'd0, 24'sh0}, 6'd0, CHK_FIXED, '{16'sh0000, 1'b0}},
        // raise the tap count mid-stream: warm-up resumes from the kept fill count
        '{ROW_TAPS, NO_ITEM, 6'd12, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd11, 24'sh010000}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd31, 24'sh7fffff}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh1234, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh5a5a, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sha5a5, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'shfffe, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh0064, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        // zero taps behaves as one tap
        '{ROW_TAPS, NO_ITEM, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh4000, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT},
        // above the maximum clamps to 32 taps, still warming up here
        '{ROW_TAPS, NO_ITEM, 6'd63, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_COEF_WRITE, 16'sh0, 5'd0, 24'sh010000}, 6'd0, CHK_MODEL, NO_OUT},
        '{ROW_ITEM, '{OP_SAMPLE, 16'sh0007, 5'd0, 24'sh0}, 6'd0, CHK_MODEL, NO_OUT}
    };

    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       cfg_write  = 1'b0;
    logic [TAPCNT_W-1:0]        cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic                       operation  = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0] sample_in  = '0;
    logic [INDEX_W-1:0]         coef_index = '0;
    logic signed [COEF_W-1:0]   coef_value = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_smp [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_tab [MAX_TAPS];
    int                         fill_cnt;
    logic [TAPCNT_W-1:0]        tap_reg;

    fir_out_t filtered_q [$];
    int       mismatch_count = 0;
    int       tx_idle_pct    = 0;
    int       rx_idle_pct    = 0;
    bit       hold_pending   = 1'b0;

    fir_filter #(.MAX_TAPS(MAX_TAPS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one accepted transaction to the predictor state.
    function automatic void filter_step(input fir_item_t it, output bit has,
                                        output fir_out_t res);
        longint acc;
        longint q;
        int     n;
        acc = 0;
        has = 1'b0;
        res = '0;
        if (it.op == OP_COEF_WRITE)
        begin
            coef_tab[it.idx] = it.coef;
            return;
        end
        for (int k = MAX_TAPS - 1; k > 0; k--)
            hist_smp[k] = hist_smp[k-1];
        hist_smp[0] = it.smp;
        if (fill_cnt < MAX_TAPS)
            fill_cnt++;
        n = (tap_reg == 0) ? 1 : ((tap_reg > MAX_TAPS) ? MAX_TAPS : int'(tap_reg));
        if (fill_cnt < n)
            return;
        for (int k = 0; k < n; k++)
            acc += longint'(coef_tab[k]) * longint'(hist_smp[k]);
        q = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
        has = 1'b1;
        if (q > longint'(SAMPLE_MAX))
        begin
            res.value = SAMPLE_MAX;
            res.sat   = 1'b1;
        end
        else if (q < longint'(SAMPLE_MIN))
        begin
            res.value = SAMPLE_MIN;
            res.sat   = 1'b1;
        end
        else
            res.value = q[SAMPLE_W-1:0];
    endfunction

    // Mostly fractions within +-1/16 so that long sums saturate only now and then.
    function automatic logic signed [COEF_W-1:0] small_coef();
        return COEF_W'(int'($urandom_range(8191)) - 4096);
    endfunction

    function automatic fir_item_t random_item();
        fir_item_t it;
        it.op  = ($urandom_range(99) < 20) ? OP_COEF_WRITE : OP_SAMPLE;
        it.idx = INDEX_W'($urandom);
        case ($urandom_range(7))
            0:       it.smp = SAMPLE_MAX;
            1:       it.smp = SAMPLE_MIN;
            default: it.smp = SAMPLE_W'($urandom);
        endcase
        case ($urandom_range(19))
            0:       it.coef = COEF_W'($urandom);
            1:       it.coef = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            2, 3:    it.coef = '0;
            default: it.coef = small_coef();
        endcase
        return it;
    endfunction

    // Offer one transaction; in_valid stays high on return so back-to-back items need no gap.
    task automatic send_item(input fir_item_t it, input bit use_fixed, input fir_out_t fixed);
        bit       has;
        fir_out_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= it.op;
        sample_in  <= it.smp;
        coef_index <= it.idx;
        coef_value <= it.coef;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filter_step(it, has, res);
        if (use_fixed)
            filtered_q.push_back(fixed);
        else if (has)
            filtered_q.push_back(res);
    endtask

    // Tap count changes only with the filter drained and quiet.
    task automatic write_taps(input logic [TAPCNT_W-1:0] taps);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= taps;
        @(posedge clk);
        cfg_write <= 1'b0;
        tap_reg = taps;
    endtask

    initial
    begin
        fir_item_t it;
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            hist_smp[k] = '0;
            coef_tab[k] = '0;
        end
        fill_cnt = 0;
        tap_reg  = 6'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (directed_steps[r].kind == ROW_TAPS)
                write_taps(directed_steps[r].taps);
            else
                send_item(directed_steps[r].item, directed_steps[r].chk == CHK_FIXED,
                          directed_steps[r].fixed);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_taps(PHASE_TAPS[p]);
            tx_idle_pct = (p < 2) ? 22 : ((p < 4) ? 57 : 0);
            rx_idle_pct = (p < 2) ? 57 : ((p < 4) ? 22 : 0);
            if (p == 3)
                hold_pending = 1'b1;
            // fresh coefficient set, then a random mix
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                it      = random_item();
                it.op   = OP_COEF_WRITE;
                it.idx  = INDEX_W'(k);
                it.coef = small_coef();
                send_item(it, 1'b0, NO_OUT);
            end
            for (int i = MAX_TAPS; i < PHASE_ITEMS; i++)
                send_item(random_item(), 1'b0, NO_OUT);
        end

        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Output side stall; one long hold-off lets the filter back up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin
        fir_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction sample_out %0d saturated %0d",
                             $realtime, sample_out, saturated);
                    mismatch_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (sample_out !== want.value)
                    begin
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $realtime, want.value, sample_out);
                        mismatch_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %0d actual %0d",
                                 $realtime, want.sat, saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either channel.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
